@@ design/sqcf_pkg.sv @@
package sqcf_pkg;

   // Default and field widths.
   localparam int RADICAND_BITS_DEF = 64;
   localparam int RADICAND_W        = 64;
   localparam int TERM_W            = 33;
   localparam int OFFSET_W          = 32;
   localparam int SQUARE_W          = 2 * OFFSET_W;
   localparam int REQ_DATA_W        = 64;
   localparam int REQ_USER_W        = 1;
   localparam int RSP_DATA_W        = 40;
   localparam int RSP_USER_W        = 2;

   // Bit positions in rsp_tuser.
   localparam int RSP_USER_SQUARE  = 0;
   localparam int RSP_USER_NO_TERM = 1;

   // Request modes carried in req_tuser.
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_NEXT  = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SQRT   = 9'b000000010,
      ST_MUL_DA = 9'b000000100,
      ST_MUL_MM = 9'b000001000,
      ST_PREP_D = 9'b000010000,
      ST_DIV_D  = 9'b000100000,
      ST_PREP_A = 9'b001000000,
      ST_DIV_A  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_NEXT  = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

endpackage

@@ design/sqrt_continued_fraction_core.sv @@
// Continued fraction expansion of sqrt(n), one term per request word. A start word
// (req_tuser = 0) loads the radicand from req_tdata and answers with the floor root,
// flagged last and perfect-square when n is a square. A next word (req_tuser = 1)
// answers with the following term, flagged last when it equals twice the root or
// the denominator comes out zero; a next word with no expansion running answers
// with the no-term flag. Everything runs through a bit-serial datapath: a start
// word goes through the two-bits-per-cycle root loop, and a next word through two
// shift-add multiplies (d*a, then m*m) and two restoring divisions at one quotient
// bit per cycle. Requests are taken one at a time; a finished word waits in the
// output register while the next request is accepted and worked on.
module sqrt_continued_fraction_core #(
   parameter int RADICAND_BITS = sqcf_pkg::RADICAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: radicand (64 bits).
   input  logic [sqcf_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: mode (bit 0).
   input  logic [sqcf_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tdata: term (bits 32:0), zero fill above.
   output logic [sqcf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: perfect_square (bit 0), no_term (bit 1).
   output logic [sqcf_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);
   import sqcf_pkg::*;

   localparam int ROOT_W   = (RADICAND_BITS + 1) / 2;
   localparam int SQ_SR_W  = 2 * ROOT_W;
   localparam int SREM_W   = ROOT_W + 1;
   localparam int DIV_W    = (RADICAND_BITS > TERM_W) ? RADICAND_BITS : TERM_W;
   localparam int CNT_W    = $clog2(DIV_W);

   state_type                 state_ff, state_in;
   kind_type                  kind_ff, kind_in;
   logic                      active_ff, active_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic [RADICAND_BITS-1:0]  held_n_ff, held_n_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [OFFSET_W-1:0]       m_ff, m_in;
   logic [TERM_W-1:0]         d_ff, d_in;
   logic [TERM_W-1:0]         a_ff, a_in;
   logic                      square_ff, square_in;

   logic [SQ_SR_W-1:0]        sq_sr_ff, sq_sr_in;
   logic [SREM_W-1:0]         srem_ff, srem_in;

   logic [SQUARE_W-1:0]       acc_ff, acc_in;
   logic [OFFSET_W-1:0]       mcand_ff, mcand_in;
   logic [OFFSET_W-1:0]       mplier_ff, mplier_in;

   logic [DIV_W-1:0]          dvd_ff, dvd_in;
   logic [TERM_W-1:0]         drem_ff, drem_in;
   logic [TERM_W-1:0]         quo_ff, quo_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TERM_W-1:0]         rsp_term_ff, rsp_term_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_square_ff, rsp_square_in;
   logic                      rsp_none_ff, rsp_none_in;

   // Root step signals.
   logic [SREM_W+1:0]         sq_shift;
   logic [SREM_W+1:0]         sq_trial;
   logic                      sq_ge;
   logic [SREM_W-1:0]         sq_rem_next;
   logic [ROOT_W-1:0]         root_next;

   // Multiply and divide step signals.
   logic [SQUARE_W-1:0]       acc_next;
   logic [OFFSET_W-1:0]       m_new;
   logic [TERM_W:0]           div_trial;
   logic                      div_ge;
   logic [TERM_W-1:0]         drem_next;
   logic [TERM_W-1:0]         quo_next;

   logic                      sq_fits;
   logic [RADICAND_BITS-1:0]  diff_n;
   logic [TERM_W-1:0]         sum_rm;
   logic [TERM_W-1:0]         two_r;
   logic                      out_free;
   logic                      cnt_last;

   logic [TERM_W-1:0]         res_term;
   logic                      res_last;
   logic                      res_square;
   logic                      res_none;
   logic                      res_active;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_term_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_none_ff, rsp_square_ff};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_last = (cnt_ff == '0);

   // Digit-by-digit root: two radicand bits enter per cycle.
   assign sq_shift    = {srem_ff, sq_sr_ff[SQ_SR_W-1 -: 2]};
   assign sq_trial    = (SREM_W + 2)'({root_ff, 2'b01});
   assign sq_ge       = (sq_shift >= sq_trial);
   assign sq_rem_next = sq_ge ? SREM_W'(sq_shift - sq_trial) : SREM_W'(sq_shift);
   assign root_next   = {root_ff[ROOT_W-2:0], sq_ge};

   // Shift-add multiplier, multiplier bits taken from the top.
   assign acc_next = {acc_ff[SQUARE_W-2:0], 1'b0}
                     + (mplier_ff[OFFSET_W-1] ? SQUARE_W'(mcand_ff) : '0);
   assign m_new    = acc_next[OFFSET_W-1:0] - m_ff;

   // Restoring divider; the divisor is always the held denominator.
   assign div_trial = {drem_ff, dvd_ff[DIV_W-1]};
   assign div_ge    = (div_trial >= {1'b0, d_ff});
   assign drem_next = div_ge ? TERM_W'(div_trial - {1'b0, d_ff}) : TERM_W'(div_trial);
   assign quo_next  = {quo_ff[TERM_W-2:0], div_ge};

   assign sq_fits = (acc_ff <= SQUARE_W'(held_n_ff));
   assign diff_n  = held_n_ff - acc_ff[RADICAND_BITS-1:0];
   assign sum_rm  = TERM_W'(root_ff) + TERM_W'(m_ff);
   assign two_r   = {TERM_W'(root_ff)} << 1;

   always_comb begin
      res_term   = '0;
      res_last   = 1'b0;
      res_square = 1'b0;
      res_none   = 1'b0;
      res_active = active_ff;
      unique case (kind_ff)
         KIND_START: begin
            res_term   = a_ff;
            res_last   = square_ff;
            res_square = square_ff;
            res_active = !square_ff;
         end
         KIND_NEXT: begin
            res_term   = a_ff;
            res_last   = (d_ff == '0) || (a_ff == two_r);
            res_active = !res_last;
         end
         KIND_NONE: begin
            res_none = 1'b1;
         end
         default: begin
            res_none = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      active_in     = active_ff;
      cnt_in        = cnt_ff;
      held_n_in     = held_n_ff;
      root_in       = root_ff;
      m_in          = m_ff;
      d_in          = d_ff;
      a_in          = a_ff;
      square_in     = square_ff;
      sq_sr_in      = sq_sr_ff;
      srem_in       = srem_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      dvd_in        = dvd_ff;
      drem_in       = drem_ff;
      quo_in        = quo_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_term_in   = rsp_term_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_square_in = rsp_square_ff;
      rsp_none_in   = rsp_none_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == MODE_START) begin
                  held_n_in = req_tdata[RADICAND_BITS-1:0];
                  sq_sr_in  = SQ_SR_W'(req_tdata[RADICAND_BITS-1:0]);
                  root_in   = '0;
                  srem_in   = '0;
                  m_in      = '0;
                  d_in      = TERM_W'(1);
                  kind_in   = KIND_START;
                  cnt_in    = CNT_W'(ROOT_W - 1);
                  state_in  = ST_SQRT;
               end else if (active_ff) begin
                  kind_in   = KIND_NEXT;
                  acc_in    = '0;
                  mcand_in  = d_ff[OFFSET_W-1:0];
                  mplier_in = a_ff[OFFSET_W-1:0];
                  cnt_in    = CNT_W'(OFFSET_W - 1);
                  state_in  = ST_MUL_DA;
               end else begin
                  kind_in  = KIND_NONE;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SQRT: begin
            sq_sr_in = sq_sr_ff << 2;
            srem_in  = sq_rem_next;
            root_in  = root_next;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_last) begin
               a_in      = TERM_W'(root_next);
               square_in = (sq_rem_next == '0);
               state_in  = ST_DONE;
            end
         end
         ST_MUL_DA: begin
            acc_in    = acc_next;
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_last) begin
               // Only the low 32 bits of d*a - m are kept.
               m_in      = m_new;
               acc_in    = '0;
               mcand_in  = m_new;
               mplier_in = m_new;
               cnt_in    = CNT_W'(OFFSET_W - 1);
               state_in  = ST_MUL_MM;
            end
         end
         ST_MUL_MM: begin
            acc_in    = acc_next;
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_last) begin
               state_in = ST_PREP_D;
            end
         end
         ST_PREP_D: begin
            if ((d_ff != '0) && sq_fits) begin
               dvd_in   = DIV_W'(diff_n);
               drem_in  = '0;
               quo_in   = '0;
               cnt_in   = CNT_W'(DIV_W - 1);
               state_in = ST_DIV_D;
            end else begin
               d_in     = '0;
               a_in     = '0;
               state_in = ST_DONE;
            end
         end
         ST_DIV_D: begin
            dvd_in  = dvd_ff << 1;
            drem_in = drem_next;
            quo_in  = quo_next;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_last) begin
               // Quotient bits above the term width fall off the shift register.
               d_in     = quo_next;
               state_in = ST_PREP_A;
            end
         end
         ST_PREP_A: begin
            if (d_ff != '0) begin
               dvd_in   = DIV_W'(sum_rm) << (DIV_W - TERM_W);
               drem_in  = '0;
               quo_in   = '0;
               cnt_in   = CNT_W'(TERM_W - 1);
               state_in = ST_DIV_A;
            end else begin
               a_in     = '0;
               state_in = ST_DONE;
            end
         end
         ST_DIV_A: begin
            dvd_in  = dvd_ff << 1;
            drem_in = drem_next;
            quo_in  = quo_next;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_last) begin
               a_in     = quo_next;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_term_in   = res_term;
               rsp_last_in   = res_last;
               rsp_square_in = res_square;
               rsp_none_in   = res_none;
               active_in     = res_active;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      cnt_ff        <= cnt_in;
      held_n_ff     <= held_n_in;
      root_ff       <= root_in;
      m_ff          <= m_in;
      d_ff          <= d_in;
      a_ff          <= a_in;
      square_ff     <= square_in;
      sq_sr_ff      <= sq_sr_in;
      srem_ff       <= srem_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      dvd_ff        <= dvd_in;
      drem_ff       <= drem_in;
      quo_ff        <= quo_in;
      rsp_term_ff   <= rsp_term_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_square_ff <= rsp_square_in;
      rsp_none_ff   <= rsp_none_in;
   end

endmodule
